[hw/rtl/spc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse scaler package
// Shared constants, command codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int RATIO_BITS_DEF = 9;
  localparam int NUM_CH         = 4;
  localparam int PULSE_W        = 16;
  localparam int WORD_W         = 20;

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd1100;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd1900;

  // Item command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CORK  = 2'd1;
  localparam logic [1:0] CMD_PUSH  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MIN_PULSE = 1'b0;
  localparam logic REG_MAX_PULSE = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;    // capture the accepted request
    logic load;     // clamp, form the numerator and prime the divider
    logic step;     // one restoring division step
    logic finish;   // commit state and load the output register
  } spc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;  // request is a write that changes a channel
    logic div_last;  // final division step in progress
    logic out_free;  // output register can take a new result
  } spc_sts_t;

endpackage
`default_nettype wire

[hw/rtl/spc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse scaler channel interfaces
// Valid/ready request and result channels with their payloads.
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  channel;
  logic [15:0] pulse_us;

  modport source (output valid, output command, output channel, output pulse_us,
                  input ready);
  modport sink   (input valid, input command, input channel, input pulse_us,
                  output ready);
endinterface

interface spc_out_if;
  logic        valid;
  logic        ready;
  logic        sent;
  logic [19:0] ratio_word_0;
  logic [19:0] ratio_word_1;
  logic [19:0] ratio_word_2;
  logic [19:0] ratio_word_3;
  logic [15:0] readback_pulse;

  modport source (output valid, output sent, output ratio_word_0, output ratio_word_1,
                  output ratio_word_2, output ratio_word_3, output readback_pulse,
                  input ready);
  modport sink   (input valid, input sent, input ratio_word_0, input ratio_word_1,
                  input ratio_word_2, input ratio_word_3, input readback_pulse,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/spc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse scaler controller
// Sequences capture, divider priming, division steps and result commit.
// ----------------------------------------------------------------------------
module spc_ctrl
  import spc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire spc_sts_t sts,
  output spc_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.need_div) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

endmodule
`default_nettype wire

[hw/rtl/spc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse scaler datapath
// Channel state, range registers, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module spc_dp
  import spc_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic                wr_index,
  input  wire logic [PULSE_W-1:0]  wr_data,
  input  wire logic [1:0]          req_command,
  input  wire logic [2:0]          req_channel,
  input  wire logic [PULSE_W-1:0]  req_pulse,
  input  wire spc_cmd_t            cmd,
  output spc_sts_t                 sts,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic                     res_sent,
  output logic [WORD_W-1:0]        res_word [NUM_CH],
  output logic [PULSE_W-1:0]       res_readback
);

  localparam int NUM_W = PULSE_W + RATIO_BITS;
  localparam int CNT_W = $clog2(RATIO_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATIO_BITS - 1);
  localparam logic [WORD_W-1:0] PREC_WORD = WORD_W'(RATIO_BITS << 16);

  logic [PULSE_W-1:0]    min_pulse;
  logic [PULSE_W-1:0]    max_pulse;
  logic [1:0]            cmd_q;
  logic [2:0]            ch_q;
  logic [PULSE_W-1:0]    pulse_q;
  logic [PULSE_W-1:0]    stored [NUM_CH];
  logic [RATIO_BITS-1:0] ratio [NUM_CH];
  logic                  pending;
  logic                  hold;
  logic [PULSE_W-1:0]    rem;
  logic [RATIO_BITS-1:0] quo;
  logic [PULSE_W-1:0]    dvs;
  logic [CNT_W-1:0]      cnt;

  // Item decode from the captured request.
  logic                  ch_ok;
  logic [1:0]            ch_idx;
  logic                  is_write;
  logic                  changed;
  logic                  pend_after;
  logic                  do_push;
  logic                  sent;

  assign ch_ok      = ~ch_q[2];
  assign ch_idx     = ch_q[1:0];
  assign is_write   = (cmd_q == CMD_WRITE);
  assign changed    = is_write && ch_ok && (pulse_q != stored[ch_idx]);
  assign pend_after = pending | changed;
  assign do_push    = (cmd_q == CMD_PUSH) || (is_write && !hold);
  assign sent       = do_push && pend_after;

  // Clamp and numerator (x * (2^R - 1)) for the divider.
  logic                  zero_rng;
  logic [PULSE_W-1:0]    span;
  logic [PULSE_W-1:0]    x;
  logic [NUM_W-1:0]      num;

  assign zero_rng = (max_pulse <= min_pulse);
  assign span     = max_pulse - min_pulse;

  always_comb begin
    priority if (zero_rng || pulse_q < min_pulse) begin
      x = '0;
    end else if (pulse_q > max_pulse) begin
      x = span;
    end else begin
      x = pulse_q - min_pulse;
    end
  end

  assign num = {x, {RATIO_BITS{1'b0}}} - NUM_W'(x);

  // One restoring division step.
  logic [PULSE_W:0] rem_sh;
  logic [PULSE_W:0] diff;
  logic             ge;

  assign rem_sh = {rem, quo[RATIO_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q   <= req_command;
      ch_q    <= req_channel;
      pulse_q <= req_pulse;
    end
    if (cmd.load) begin
      rem <= num[NUM_W-1:RATIO_BITS];
      quo <= num[RATIO_BITS-1:0];
      dvs <= zero_rng ? PULSE_W'(1) : span;
      cnt <= '0;
    end else if (cmd.step) begin
      rem <= ge ? diff[PULSE_W-1:0] : rem_sh[PULSE_W-1:0];
      quo <= {quo[RATIO_BITS-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  // Channel state after this item.
  logic [PULSE_W-1:0]    stored_after [NUM_CH];
  logic [RATIO_BITS-1:0] ratio_after  [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      stored_after[k] = stored[k];
      ratio_after[k]  = ratio[k];
      if (changed && ch_idx == 2'(k)) begin
        stored_after[k] = pulse_q;
        ratio_after[k]  = quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse <= MIN_PULSE_RST;
      max_pulse <= MAX_PULSE_RST;
      pending   <= 1'b0;
      hold      <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        stored[k] <= '0;
        ratio[k]  <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_MIN_PULSE: min_pulse <= wr_data;
          REG_MAX_PULSE: max_pulse <= wr_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        stored    <= stored_after;
        ratio     <= ratio_after;
        pending   <= pend_after && !sent;
        if (cmd_q == CMD_CORK) begin
          hold <= 1'b1;
        end else if (do_push) begin
          hold <= 1'b0;
        end
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_sent     <= sent;
      res_readback <= ch_ok ? stored_after[ch_idx] : '0;
      for (int k = 0; k < NUM_CH; k++) begin
        res_word[k] <= sent ? (PREC_WORD | WORD_W'(ratio_after[k])) : '0;
      end
    end
  end

  assign sts.need_div = changed;
  assign sts.div_last = (cnt == CNT_LAST);
  assign sts.out_free = !res_valid || res_ready;

endmodule
`default_nettype wire

[hw/rtl/servo_pulse_to_pwm_ratio.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo pulse to PWM ratio scaler
// Four-channel motor output block: clamps and scales pulse widths to ratios,
// with cork and push control of when the ratio words are issued.
// ----------------------------------------------------------------------------
// Sequence: a request that changes a channel is captured, primes the
// divider, takes one restoring division step per ratio bit and is then
// committed to the output register; other requests skip the divider.
// Requests: one at a time; the next is accepted on the cycle after the
// result is committed. The restoring divider yields one quotient bit per
// cycle. A result that is not taken holds the commit back until it is taken.
// Reset (rst, synchronous, active high) clears all channel state, the pending
// and hold flags and the output valid flag, and restores 1100/1900 us as range.
// ----------------------------------------------------------------------------
module servo_pulse_to_pwm_ratio
  import spc_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  spc_in_if.sink                  pulse_in,
  spc_out_if.source               ratio_out,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [PULSE_W-1:0] wr_data
);

  localparam logic [WORD_W-1:0] PREC_WORD = WORD_W'(RATIO_BITS << 16);

  spc_cmd_t            cmd;
  spc_sts_t            sts;
  logic [WORD_W-1:0]   word [NUM_CH];

  // The controller owns the request handshake: a request is taken only when
  // the previous one has been committed to the output register.
  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (pulse_in.valid),
    .req_ready (pulse_in.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the channel state and range registers, runs the
  // divider for a changed pulse width and keeps the result until it is taken.
  spc_dp #(
    .RATIO_BITS (RATIO_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .req_command  (pulse_in.command),
    .req_channel  (pulse_in.channel),
    .req_pulse    (pulse_in.pulse_us),
    .cmd          (cmd),
    .sts          (sts),
    .res_valid    (ratio_out.valid),
    .res_ready    (ratio_out.ready),
    .res_sent     (ratio_out.sent),
    .res_word     (word),
    .res_readback (ratio_out.readback_pulse)
  );

  assign ratio_out.ratio_word_0 = word[0];
  assign ratio_out.ratio_word_1 = word[1];
  assign ratio_out.ratio_word_2 = word[2];
  assign ratio_out.ratio_word_3 = word[3];

  // A new result appears only as the controller commits a request.
  a_result_from_finish : assert property (@(posedge clk) disable iff (rst)
    $rose(ratio_out.valid) |-> $past(cmd.finish))
    else $error("result appeared without a commit");

  // Requests are worked one at a time.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    (pulse_in.valid && pulse_in.ready) |=> !pulse_in.ready)
    else $error("request accepted while busy");

  // An issued update carries the precision field; words 0 and 3 are checked.
  a_sent_precision : assert property (@(posedge clk) disable iff (rst)
    (ratio_out.valid && ratio_out.sent) |->
      (ratio_out.ratio_word_0[19:16] == PREC_WORD[19:16]) &&
      (ratio_out.ratio_word_3[19:16] == PREC_WORD[19:16]))
    else $error("issued word lacks precision field");

  // Without an update the words stay at zero.
  a_unsent_zero : assert property (@(posedge clk) disable iff (rst)
    (ratio_out.valid && !ratio_out.sent) |->
      (ratio_out.ratio_word_0 == '0) && (ratio_out.ratio_word_1 == '0) &&
      (ratio_out.ratio_word_2 == '0) && (ratio_out.ratio_word_3 == '0))
    else $error("words non-zero without an update");

endmodule
`default_nettype wire
